// ===== src/dtslm_pkg.sv =====
package dtslm_pkg;

	localparam int unsigned LenW   = 24;
	localparam int unsigned ErrW   = LenW + 1;
	localparam int unsigned DzW    = 20;
	localparam int unsigned ScaleW = 24;
	localparam int unsigned OffW   = 7;
	localparam int unsigned DriveW = 8;
	localparam int unsigned CfgW   = 24;
	localparam int unsigned ProdW  = ErrW + ScaleW;
	localparam int unsigned FracW  = 16;

	localparam logic [DriveW-1:0] NEUTRAL  = 8'd90;
	localparam logic [OffW-1:0]   OFF_MAX  = 7'd90;
	localparam logic [LenW-1:0]   TICK_MAX = 24'hFFFFFF;

	localparam logic [DzW-1:0]    DZ_RESET    = 20'd1000;
	localparam logic [ScaleW-1:0] SCALE_RESET = 24'd1311;
	localparam logic [OffW-1:0]   OFF_RESET   = 7'd10;

	typedef enum logic [1:0] {
		CFG_DEADZONE   = 2'd0,
		CFG_TIME_SCALE = 2'd1,
		CFG_DRIVE_OFF  = 2'd2
	} cfg_idx_t;

	typedef enum logic {
		KIND_TICK   = 1'b0,
		KIND_TARGET = 1'b1
	} kind_t;

	typedef enum logic [1:0] {
		ST_EVAL  = 2'd0,
		ST_MUL_L = 2'd1,
		ST_MUL_R = 2'd2
	} back_state_t;

	typedef struct packed {
		logic                   req_type;
		logic signed [LenW-1:0] target_left;
		logic signed [LenW-1:0] target_right;
	} req_t;

	typedef struct packed {
		logic [DriveW-1:0] left_drive;
		logic [DriveW-1:0] right_drive;
		logic              moving;
	} rsp_t;

	typedef struct packed {
		kind_t                  kind;
		logic signed [LenW-1:0] target_left;
		logic signed [LenW-1:0] target_right;
	} cmd_t;

	typedef struct packed {
		logic [DzW-1:0]    deadzone;
		logic [ScaleW-1:0] time_scale;
		logic [OffW-1:0]   drive_offset;
	} cfg_t;

endpackage

// ===== src/dtslm_front.sv =====
module dtslm_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  dtslm_pkg::req_t    in_req,
	output logic               cmd_valid,
	output dtslm_pkg::cmd_t    cmd,
	input  logic               cmd_pop
);
	import dtslm_pkg::*;

	cmd_t       mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       push;
	cmd_t       cmd_in;

	// classify the request into a command for the back end
	always_comb begin
		cmd_in.kind         = in_req.req_type ? KIND_TARGET : KIND_TICK;
		cmd_in.target_left  = in_req.target_left;
		cmd_in.target_right = in_req.target_right;
	end

	assign in_ready  = (count_q != 2'd2);
	assign push      = in_valid & in_ready;
	assign cmd_valid = (count_q != 2'd0);
	assign cmd       = mem_q[rd_ptr_q];

	// store commands
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= cmd_in;
		end
	end

	// advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (cmd_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, cmd_pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== src/dtslm_back.sv =====
module dtslm_back (
	input  logic               clk,
	input  logic               arst_n,
	input  dtslm_pkg::cfg_t    cfg,
	input  logic               cmd_valid,
	input  dtslm_pkg::cmd_t    cmd,
	output logic               cmd_pop,
	output logic               out_valid,
	input  logic               out_ready,
	output dtslm_pkg::rsp_t    out_rsp
);
	import dtslm_pkg::*;

	back_state_t state_q, state_d;

	logic signed [LenW-1:0] cur_l_q, cur_r_q;
	logic signed [LenW-1:0] des_l_q, des_r_q;
	logic signed [LenW-1:0] goal_l_q, goal_r_q;
	logic [LenW-1:0]        time_l_q, time_r_q;
	logic [LenW-1:0]        elapsed_q;
	logic [DriveW-1:0]      drive_l_q, drive_r_q;
	logic [1:0]             done_q;
	logic                   active_q;
	logic [ErrW-1:0]        mag_l_q, mag_r_q;
	logic                   out_valid_q;
	rsp_t                   out_rsp_q;

	logic                   out_free;
	logic                   emit;
	logic                   do_tick;
	logic                   do_start;
	logic                   do_target;
	rsp_t                   rsp_d;

	logic signed [LenW-1:0] des_l_d, des_r_d;
	logic signed [ErrW-1:0] err_l, err_r;
	logic [ErrW-1:0]        mag_l, mag_r;
	logic                   start_w;
	logic [OffW-1:0]        off;
	logic [DriveW-1:0]      pick_l, pick_r;

	logic [LenW-1:0]        elapsed_d;
	logic                   fin_l, fin_r;
	logic [1:0]             done_d;
	logic                   both_done;
	logic [DriveW-1:0]      tick_drive_l, tick_drive_r;

	logic [ErrW-1:0]        mul_a;
	logic [ProdW-1:0]       prod;
	logic [ProdW-FracW-1:0] prod_sh;
	logic [LenW-1:0]        run_time;

	assign out_free = !out_valid_q || out_ready;

	// error and drive selection for a possible move start
	always_comb begin
		do_target = (cmd.kind == KIND_TARGET);
		des_l_d   = do_target ? cmd.target_left  : des_l_q;
		des_r_d   = do_target ? cmd.target_right : des_r_q;
		err_l     = {des_l_d[LenW-1], des_l_d} - {cur_l_q[LenW-1], cur_l_q};
		err_r     = {des_r_d[LenW-1], des_r_d} - {cur_r_q[LenW-1], cur_r_q};
		mag_l     = err_l[ErrW-1] ? ErrW'(-err_l) : ErrW'(err_l);
		mag_r     = err_r[ErrW-1] ? ErrW'(-err_r) : ErrW'(err_r);
		start_w   = (mag_l > {5'b0, cfg.deadzone}) || (mag_r > {5'b0, cfg.deadzone});
		off       = (cfg.drive_offset > OFF_MAX) ? OFF_MAX : cfg.drive_offset;
		if (mag_l < {5'b0, cfg.deadzone}) begin
			pick_l = NEUTRAL;
		end else if (!err_l[ErrW-1] && (err_l != '0)) begin
			pick_l = NEUTRAL + {1'b0, off};
		end else begin
			pick_l = NEUTRAL - {1'b0, off};
		end
		if (mag_r < {5'b0, cfg.deadzone}) begin
			pick_r = NEUTRAL;
		end else if (!err_r[ErrW-1] && (err_r != '0)) begin
			pick_r = NEUTRAL + {1'b0, off};
		end else begin
			pick_r = NEUTRAL - {1'b0, off};
		end
	end

	// one tick of a running move
	always_comb begin
		elapsed_d    = (elapsed_q != TICK_MAX) ? elapsed_q + 1'b1 : elapsed_q;
		fin_l        = !done_q[0] && ((elapsed_d > time_l_q) || (elapsed_d == TICK_MAX));
		fin_r        = !done_q[1] && ((elapsed_d > time_r_q) || (elapsed_d == TICK_MAX));
		done_d       = {done_q[1] | fin_r, done_q[0] | fin_l};
		both_done    = done_d[0] & done_d[1];
		tick_drive_l = (fin_l || both_done) ? NEUTRAL : drive_l_q;
		tick_drive_r = (fin_r || both_done) ? NEUTRAL : drive_r_q;
	end

	// shared run-time multiplier, saturated to the tick range
	always_comb begin
		mul_a    = (state_q == ST_MUL_L) ? mag_l_q : mag_r_q;
		prod     = ProdW'(mul_a) * ProdW'(cfg.time_scale);
		prod_sh  = prod[ProdW-1:FracW];
		run_time = (|prod_sh[ProdW-FracW-1:LenW]) ? TICK_MAX : prod_sh[LenW-1:0];
	end

	// sequence: evaluate, then two multiply steps for a move start
	always_comb begin
		state_d  = state_q;
		cmd_pop  = 1'b0;
		emit     = 1'b0;
		do_tick  = 1'b0;
		do_start = 1'b0;
		rsp_d.left_drive  = drive_l_q;
		rsp_d.right_drive = drive_r_q;
		rsp_d.moving      = active_q;
		unique case (state_q)
			ST_EVAL: begin
				if (cmd_valid && out_free) begin
					cmd_pop = 1'b1;
					if (!do_target && active_q) begin
						do_tick = 1'b1;
						emit    = 1'b1;
						rsp_d.left_drive  = tick_drive_l;
						rsp_d.right_drive = tick_drive_r;
						rsp_d.moving      = !both_done;
					end else if (!active_q && start_w) begin
						do_start = 1'b1;
						state_d  = ST_MUL_L;
					end else begin
						emit = 1'b1;
					end
				end
			end
			ST_MUL_L: begin
				state_d = ST_MUL_R;
			end
			ST_MUL_R: begin
				if (out_free) begin
					emit    = 1'b1;
					state_d = ST_EVAL;
				end
			end
			default: begin
				state_d = ST_EVAL;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_EVAL;
		end else begin
			state_q <= state_d;
		end
	end

	// hold error magnitudes for the multiply steps
	always_ff @(posedge clk) begin
		if (do_start) begin
			mag_l_q <= mag_l;
			mag_r_q <= mag_r;
		end
	end

	// update move state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_l_q   <= '0;
			cur_r_q   <= '0;
			des_l_q   <= '0;
			des_r_q   <= '0;
			goal_l_q  <= '0;
			goal_r_q  <= '0;
			time_l_q  <= '0;
			time_r_q  <= '0;
			elapsed_q <= '0;
			drive_l_q <= NEUTRAL;
			drive_r_q <= NEUTRAL;
			done_q    <= 2'b11;
			active_q  <= 1'b0;
		end else begin
			if (cmd_pop && do_target) begin
				des_l_q <= cmd.target_left;
				des_r_q <= cmd.target_right;
			end
			if (do_tick) begin
				elapsed_q <= elapsed_d;
				done_q    <= done_d;
				drive_l_q <= tick_drive_l;
				drive_r_q <= tick_drive_r;
				if (both_done) begin
					active_q <= 1'b0;
					cur_l_q  <= goal_l_q;
					cur_r_q  <= goal_r_q;
				end
			end
			if (do_start) begin
				goal_l_q  <= des_l_d;
				goal_r_q  <= des_r_d;
				drive_l_q <= pick_l;
				drive_r_q <= pick_r;
				done_q    <= 2'b00;
				elapsed_q <= '0;
				active_q  <= 1'b1;
			end
			if (state_q == ST_MUL_L) begin
				time_l_q <= run_time;
			end
			if (state_q == ST_MUL_R) begin
				time_r_q <= run_time;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_rsp_q <= rsp_d;
		end
	end

	assign out_valid = out_valid_q;
	assign out_rsp   = out_rsp_q;

endmodule

// ===== src/dual_timed_servo_length_move.sv =====
// Two-channel timed line-length controller for continuous-rotation servos.
// Input channel (in_valid/in_ready/in_req): each request is a one millisecond
// tick (req_type 0) or a pair of new target lengths (req_type 1). Every
// request yields exactly one response on out_valid/out_ready/out_rsp with
// both servo commands (90 = stop) and the moving flag after that request.
// Requests land in a two-entry command queue; the executor works them off.
// A response passes the command queue and then the output register when no
// move starts; a request that starts a move also passes the multiply steps
// ST_MUL_L and ST_MUL_R, as the executor computes both run times one after
// another on a single multiplier. Throughput: one request per cycle while the
// receiver takes responses; a move start holds off the next request through its multiply steps.
// Configuration: cfg_we writes cfg_data to register cfg_index (0 deadzone,
// 1 time_scale, 2 drive_offset) and must be used only while no request is
// in flight. Reset restores register defaults, zero lengths, neutral drives.
// When the receiver stalls, the response waits in the output register, the
// queue fills, and in_ready drops once two requests are queued.
module dual_timed_servo_length_move (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  dtslm_pkg::req_t            in_req,
	output logic                       out_valid,
	input  logic                       out_ready,
	output dtslm_pkg::rsp_t            out_rsp,
	input  logic                       cfg_we,
	input  logic [1:0]                 cfg_index,
	input  logic [dtslm_pkg::CfgW-1:0] cfg_data
);
	import dtslm_pkg::*;

	cfg_t cfg_q;
	logic cmd_valid;
	cmd_t cmd;
	logic cmd_pop;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.deadzone     <= DZ_RESET;
			cfg_q.time_scale   <= SCALE_RESET;
			cfg_q.drive_offset <= OFF_RESET;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_DEADZONE:   cfg_q.deadzone     <= cfg_data[DzW-1:0];
				CFG_TIME_SCALE: cfg_q.time_scale   <= cfg_data[ScaleW-1:0];
				CFG_DRIVE_OFF:  cfg_q.drive_offset <= cfg_data[OffW-1:0];
				default:        cfg_q              <= cfg_q;
			endcase
		end
	end

	dtslm_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_req    (in_req),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop)
	);

	dtslm_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_rsp   (out_rsp)
	);

	// an idle response always shows neutral drives
	a_idle_neutral: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_rsp.moving) |->
		(out_rsp.left_drive == NEUTRAL) && (out_rsp.right_drive == NEUTRAL))
		else $error("idle response with non-neutral drive");

	// drives stay within the servo command range
	a_drive_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_rsp.left_drive <= 8'd180) && (out_rsp.right_drive <= 8'd180))
		else $error("drive command out of range");

	// the executor never pops an empty queue
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_pop |-> cmd_valid)
		else $error("command popped from empty queue");

endmodule

// ===== dv/dtslm_drive_checker.sv =====
module dtslm_drive_checker
	import dtslm_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  logic            in_ready,
	input  req_t            in_req,
	input  logic            out_valid,
	input  logic            out_ready,
	input  rsp_t            out_rsp,
	input  logic            cfg_we,
	input  logic [1:0]      cfg_index,
	input  logic [CfgW-1:0] cfg_data,
	output int              errors,
	output int              pending,
	output int              checked,
	output int              moves
);

	// register copies
	logic [DzW-1:0]    dz;
	logic [ScaleW-1:0] scale;
	logic [OffW-1:0]   offset;

	// line lengths, the move in progress and its drives
	logic signed [LenW-1:0] cur_l, cur_r, tgt_l, tgt_r, dest_l, dest_r;
	logic [LenW-1:0]        dur_l, dur_r, clock_ms;
	logic [DriveW-1:0]      drv_l, drv_r;
	logic                   done_l, done_r, active;

	rsp_t expected_drives[$];

	task automatic note_mismatch(string what, int seen, int wanted);
		if (errors < 40)
			$display("%0t dtslm_drive_checker: response %0d %s: got %0d, expected %0d",
				$time, checked, what, seen, wanted);
		errors++;
	endtask

	function automatic logic [ErrW-1:0] magnitude(logic signed [ErrW-1:0] e);
		return e[ErrW-1] ? -e : e;
	endfunction

	// ticks of travel: |error| times the Q16 scale, held at the counter limit
	function automatic logic [LenW-1:0] run_ticks(logic [ErrW-1:0] m);
		logic [ProdW-1:0] p;
		p = ProdW'(m) * ProdW'(scale);
		p = p >> FracW;
		return (|p[ProdW-1:LenW]) ? TICK_MAX : p[LenW-1:0];
	endfunction

	function automatic logic [DriveW-1:0] drive_for(logic signed [ErrW-1:0] e,
			logic [ErrW-1:0] m);
		logic [OffW-1:0] o;
		o = (offset > OFF_MAX) ? OFF_MAX : offset;
		if (m < ErrW'(dz))
			return NEUTRAL;
		return (e > 0) ? NEUTRAL + {1'b0, o} : NEUTRAL - {1'b0, o};
	endfunction

	// start a move when either error is past the deadzone
	task automatic try_move();
		logic signed [ErrW-1:0] el, er;
		logic [ErrW-1:0]        ml, mr;
		el = {tgt_l[LenW-1], tgt_l} - {cur_l[LenW-1], cur_l};
		er = {tgt_r[LenW-1], tgt_r} - {cur_r[LenW-1], cur_r};
		ml = magnitude(el);
		mr = magnitude(er);
		if (ml <= ErrW'(dz) && mr <= ErrW'(dz))
			return;
		dest_l = tgt_l;
		dest_r = tgt_r;
		dur_l = run_ticks(ml);
		dur_r = run_ticks(mr);
		drv_l = drive_for(el, ml);
		drv_r = drive_for(er, mr);
		done_l = 1'b0;
		done_r = 1'b0;
		clock_ms = '0;
		active = 1'b1;
		moves++;
	endtask

	// advance the move by one millisecond, stop channels whose time is up
	task automatic advance_move();
		if (clock_ms != TICK_MAX)
			clock_ms = clock_ms + 1'b1;
		if (!done_l && (clock_ms > dur_l || clock_ms == TICK_MAX)) begin
			done_l = 1'b1;
			drv_l = NEUTRAL;
		end
		if (!done_r && (clock_ms > dur_r || clock_ms == TICK_MAX)) begin
			done_r = 1'b1;
			drv_r = NEUTRAL;
		end
		if (done_l && done_r) begin
			active = 1'b0;
			cur_l = dest_l;
			cur_r = dest_r;
			drv_l = NEUTRAL;
			drv_r = NEUTRAL;
		end
	endtask

	task automatic apply_request(input req_t r, output rsp_t o);
		if (r.req_type == KIND_TARGET) begin
			tgt_l = r.target_left;
			tgt_r = r.target_right;
			if (!active)
				try_move();
		end else if (active) begin
			advance_move();
		end else begin
			try_move();
		end
		o.left_drive = drv_l;
		o.right_drive = drv_r;
		o.moving = active;
	endtask

	always @(posedge clk or negedge arst_n) begin
		rsp_t want, got;
		if (!arst_n) begin
			dz = DZ_RESET;
			scale = SCALE_RESET;
			offset = OFF_RESET;
			cur_l = '0;
			cur_r = '0;
			tgt_l = '0;
			tgt_r = '0;
			dest_l = '0;
			dest_r = '0;
			dur_l = '0;
			dur_r = '0;
			clock_ms = '0;
			drv_l = NEUTRAL;
			drv_r = NEUTRAL;
			done_l = 1'b1;
			done_r = 1'b1;
			active = 1'b0;
			errors = 0;
			moves = 0;
			expected_drives.delete();
			pending <= 0;
			checked <= 0;
		end else begin
			// take register writes
			if (cfg_we) begin
				case (cfg_idx_t'(cfg_index))
					CFG_DEADZONE:   dz = cfg_data[DzW-1:0];
					CFG_TIME_SCALE: scale = cfg_data[ScaleW-1:0];
					CFG_DRIVE_OFF:  offset = cfg_data[OffW-1:0];
					default: ;
				endcase
			end
			// predict the response of each accepted request
			if (in_valid && in_ready) begin
				apply_request(in_req, want);
				expected_drives.push_back(want);
			end
			// compare each response with the oldest prediction
			if (out_valid && out_ready) begin
				got = out_rsp;
				checked <= checked + 1;
				if (expected_drives.size() == 0) begin
					note_mismatch("arrived with no request waiting", got.moving, 0);
				end else begin
					want = expected_drives.pop_front();
					if (got.left_drive !== want.left_drive)
						note_mismatch("left_drive", got.left_drive, want.left_drive);
					if (got.right_drive !== want.right_drive)
						note_mismatch("right_drive", got.right_drive, want.right_drive);
					if (got.moving !== want.moving)
						note_mismatch("moving", got.moving, want.moving);
				end
			end
			pending <= expected_drives.size();
		end
	end

endmodule

// ===== dv/tb_dual_timed_servo_length_move.sv =====
module tb_dual_timed_servo_length_move;
	import dtslm_pkg::*;

	localparam int LONG_HOLD  = 250;
	localparam int FULL_RANGE = -1;

	logic            clk = 1'b0;
	logic            arst_n = 1'b0;
	logic            in_valid = 1'b0;
	logic            in_ready;
	req_t            in_req = '0;
	logic            out_valid;
	logic            out_ready = 1'b0;
	rsp_t            out_rsp;
	logic            cfg_we = 1'b0;
	logic [1:0]      cfg_index = '0;
	logic [CfgW-1:0] cfg_data = '0;

	int   errors, pending, checked, moves;
	int   sent = 0;
	int   settings = 0;
	int   hold_asked = 0;
	int   hold_served = 0;
	bit   calm = 1'b0;
	logic last_moving = 1'b0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	dual_timed_servo_length_move dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_req    (in_req),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_rsp   (out_rsp),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	dtslm_drive_checker checker_i (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_req    (in_req),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_rsp   (out_rsp),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.errors    (errors),
		.pending   (pending),
		.checked   (checked),
		.moves     (moves)
	);

	// track whether the last response still reported a move
	always @(posedge clk) begin
		if (out_valid && out_ready)
			last_moving <= out_rsp.moving;
	end

	// response side: random stalls, one long hold-off on request, none when calm
	initial begin
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_served != hold_asked) begin
				hold_served++;
				out_ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end else if (calm || $urandom_range(0, 2) != 0) begin
				out_ready <= 1'b1;
				repeat ($urandom_range(1, 20)) @(posedge clk);
			end else begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 11)) @(posedge clk);
			end
		end
	end

	// tick with junk in the unused target fields
	function automatic req_t tick_req();
		req_t r;
		r.req_type = KIND_TICK;
		r.target_left = LenW'($urandom);
		r.target_right = LenW'($urandom);
		return r;
	endfunction

	function automatic req_t target_req(int l, int r);
		req_t q;
		q.req_type = KIND_TARGET;
		q.target_left = LenW'(l);
		q.target_right = LenW'(r);
		return q;
	endfunction

	function automatic int length_near(int span);
		if (span == FULL_RANGE)
			return int'($signed(LenW'($urandom)));
		return int'($urandom_range(0, 2 * span)) - span;
	endfunction

	// hold the request until accepted, then maybe leave a gap
	task automatic offer(input req_t r);
		in_req <= r;
		in_valid <= 1'b1;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		sent++;
		if (!calm && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
	endtask

	// stop sending and wait for every outstanding response
	task automatic drain();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (pending != 0);
	endtask

	task automatic configure(input int unsigned dz, input int unsigned scale,
			input int unsigned off);
		drain();
		repeat (6) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= CFG_DEADZONE;
		cfg_data <= CfgW'(dz);
		@(posedge clk);
		cfg_index <= CFG_TIME_SCALE;
		cfg_data <= CfgW'(scale);
		@(posedge clk);
		cfg_index <= CFG_DRIVE_OFF;
		cfg_data <= CfgW'(off);
		@(posedge clk);
		cfg_we <= 1'b0;
		settings++;
	endtask

	// finish any move, then drive both lines back to zero with instant moves
	task automatic return_home();
		configure(0, 0, OFF_RESET);
		offer(target_req(0, 0));
		repeat (2) begin
			do begin
				offer(tick_req());
				drain();
			end while (last_moving);
		end
	endtask

	// targets within span of zero, each mostly followed by a run of ticks
	task automatic run_phase(input int unsigned dz, input int unsigned scale,
			input int unsigned off, input int span, input int n_items, input bit hold);
		int start;
		return_home();
		configure(dz, scale, off);
		if (hold)
			hold_asked++;
		start = sent;
		while (sent - start < n_items) begin
			if ($urandom_range(0, 9) < 8) begin
				offer(target_req(length_near(span), length_near(span)));
				repeat ($urandom_range(1, 90)) begin
					if ($urandom_range(0, 19) == 0)
						offer(target_req(length_near(span), length_near(span)));
					else
						offer(tick_req());
				end
			end else begin
				repeat ($urandom_range(1, 4)) begin
					if ($urandom_range(0, 1) == 0)
						offer(tick_req());
					else
						offer(target_req(length_near(span), length_near(span)));
				end
			end
			if ($urandom_range(0, 7) == 0)
				drain();
		end
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: idle tick, error exactly at the deadzone
		offer(tick_req());
		offer(target_req(1000, -1000));

		// one step past the deadzone, new targets held during the move
		configure(DZ_RESET, 200, OFF_RESET);
		offer(target_req(1001, -1001));
		offer(target_req(2500, -1001));
		repeat (4) offer(tick_req());
		// held targets start on the idle tick, right channel inside the deadzone
		repeat (6) offer(tick_req());

		// field extremes, offset above the clamp, zero error with zero deadzone
		configure(0, 0, 127);
		offer(target_req(8388607, -8388608));
		offer(tick_req());
		offer(target_req(-8388608, 8388607));
		offer(tick_req());
		offer(target_req(-8388608, 0));
		offer(tick_req());
		offer(tick_req());

		run_phase(DZ_RESET, SCALE_RESET, OFF_RESET, 1500, 70, 1'b1);
		run_phase(0, 0, 127, FULL_RANGE, 70, 1'b0);
		run_phase(20'hFFFFF, 24'hFFFFFF, 0, 524287, 60, 1'b0);
		run_phase(20, 65536, 45, 40, 70, 1'b0);
		run_phase(1, 1, 90, 4000000, 70, 1'b0);
		calm = 1'b1;
		run_phase(500, 2000, 5, 1200, 70, 1'b0);

		drain();
		repeat (20) @(posedge clk);
		$display("%0d requests sent, %0d responses checked, %0d moves started",
			sent, checked, moves);
		$display("register settings applied: %0d, including zero and full-scale values",
			settings);
		if (errors == 0 && pending == 0)
			$display("tb_dual_timed_servo_length_move: done, clean");
		else
			$display("tb_dual_timed_servo_length_move: done, errors");
		$finish;
	end

	// watchdog
	initial begin
		#3000000;
		$display("tb_dual_timed_servo_length_move: done, errors");
		$finish;
	end

endmodule
